// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
// Properties are sampled on the rising edge of the given clock and are off while
// the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// ante |-> cons
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// ante |=> cons
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- hdl/bmtb_pkg.sv -----
package bmtb_pkg;

  localparam int ELEMENT_WIDTH = 16;
  localparam int SUM_WIDTH     = 40;
  localparam int DEF_MAX_K     = 64;
  localparam int DEF_MAX_N     = 16;

  // config port
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 3;

  // config register widths
  localparam int CD_W  = 7;
  localparam int OC_W  = 5;
  localparam int RPS_W = 13;
  localparam int DS_W  = 9;
  localparam int BAT_W = 9;

  // result index widths
  localparam int ROW_W   = 12;
  localparam int DIM_W   = 8;
  localparam int BATCH_W = 8;
  localparam int COL_W   = 4;

  localparam int MAX_ROWS    = 4096;
  localparam int MAX_SLICES  = 256;
  localparam int MAX_BATCHES = 256;

  typedef enum logic {
    CMD_WEIGHT = 1'b0,
    CMD_ACT    = 1'b1
  } cmd_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_COMMON_DIM     = 3'd0,
    CFG_OUT_COLS       = 3'd1,
    CFG_ROWS_PER_SLICE = 3'd2,
    CFG_DIM_SLICES     = 3'd3,
    CFG_BATCHES        = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    cmd_t                            command;
    logic signed [ELEMENT_WIDTH-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic signed [SUM_WIDTH-1:0] sum;
    logic [BATCH_W-1:0]          batch_index;
    logic [DIM_W-1:0]            dim_index;
    logic [ROW_W-1:0]            row_index;
    logic [COL_W-1:0]            col_index;
    logic                        last;
  } out_res_t;

  // row buffer cell control
  typedef struct packed {
    logic wr_en;
    logic shift_en;
  } cell_ctrl_t;

  // tag that travels with each product through the MAC
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last_pos;
    logic             last_col;
    logic [COL_W-1:0] col;
  } mac_tag_t;

  // zero acts as one, anything above hi acts as hi
  function automatic int unsigned clamp_cfg(input int unsigned v, input int unsigned hi);
    int unsigned r;
    if (v == 0) begin
      r = 1;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- hdl/batched_matmul_transposed_b.sv -----
// Batched matrix product C = A * W^T with stationary weights, Q8.8 in, Q24.16 out.
// Request channel: in_data (command, value) is taken at a rising edge with start
//   high and busy low. command CMD_WEIGHT stores the next weight element (column
//   major by output column, then position), wrapping after common_dim*out_cols.
//   command CMD_ACT buffers the next element of the current A row.
// Config port: cfg_we/cfg_index/cfg_wdata write one register per edge, no wait.
//   Write only while busy is low and no row is pending in the pipe.
// Result channel: out_valid strobes each result for exactly one cycle;
//   there is no backpressure. A completed row gives out_cols results in column
//   order, last set on the final column, with batch/dim/row indices of the row.
// Flow: weight requests and non-final activation requests never raise busy.
//   The row's final request raises busy; the single MAC walks the weight memory
//   sequentially over K*N addresses (K = common_dim, N = out_cols). Results
//   come out in column order; busy drops the cycle after the last result, so
//   no new request is taken until the whole row is out. The one MAC and the
//   one-read-per-cycle weight memory limit the throughput.
// Reset (rst_n low, synchronous): pointers, counters and config registers go to
//   their defaults; weight memory and row buffer hold garbage until written.
`include "assert_macros.svh"

module batched_matmul_transposed_b import bmtb_pkg::*; #(
  parameter int MAX_K = DEF_MAX_K,
  parameter int MAX_N = DEF_MAX_N
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  in_req_t                in_data,
  output logic                   out_valid,
  output out_res_t               out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  // widths derived from the array sizes
  localparam int KW    = $clog2(MAX_K + 1);            // holds 1..MAX_K
  localparam int NW    = $clog2(MAX_N + 1);
  localparam int EPW   = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int CW    = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int DEPTH = MAX_K * MAX_N;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  logic [CD_W-1:0]  common_dim_r;
  logic [OC_W-1:0]  out_cols_r;
  logic [RPS_W-1:0] rows_per_slice_r;
  logic [DS_W-1:0]  dim_slices_r;
  logic [BAT_W-1:0] batches_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      common_dim_r     <= CD_W'(64);
      out_cols_r       <= OC_W'(16);
      rows_per_slice_r <= RPS_W'(1);
      dim_slices_r     <= DS_W'(1);
      batches_r        <= BAT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COMMON_DIM:     common_dim_r     <= cfg_wdata[CD_W-1:0];
        CFG_OUT_COLS:       out_cols_r       <= cfg_wdata[OC_W-1:0];
        CFG_ROWS_PER_SLICE: rows_per_slice_r <= cfg_wdata[RPS_W-1:0];
        CFG_DIM_SLICES:     dim_slices_r     <= cfg_wdata[DS_W-1:0];
        CFG_BATCHES:        batches_r        <= cfg_wdata[BAT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes: zero reads as one, large values saturate
  logic [KW-1:0]    k_eff;
  logic [NW-1:0]    n_eff;
  logic [RPS_W-1:0] nr_eff;
  logic [DS_W-1:0]  nd_eff;
  logic [BAT_W-1:0] nb_eff;
  logic [KW+NW-1:0] kn;

  assign k_eff  = KW'(clamp_cfg(32'(common_dim_r), MAX_K));
  assign n_eff  = NW'(clamp_cfg(32'(out_cols_r), MAX_N));
  assign nr_eff = RPS_W'(clamp_cfg(32'(rows_per_slice_r), MAX_ROWS));
  assign nd_eff = DS_W'(clamp_cfg(32'(dim_slices_r), MAX_SLICES));
  assign nb_eff = BAT_W'(clamp_cfg(32'(batches_r), MAX_BATCHES));
  assign kn     = (KW+NW)'(k_eff) * (KW+NW)'(n_eff);

  // ---------------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------------
  logic busy_r, busy_nxt;
  logic accept;
  logic wt_acc;
  logic act_acc;
  logic row_trigger;

  assign accept      = start && !busy_r;
  assign wt_acc      = accept && (in_data.command == CMD_WEIGHT);
  assign act_acc     = accept && (in_data.command == CMD_ACT);

  // ---------------------------------------------------------------------------
  // Weight pointer and weight memory (flat: col * K + pos)
  // ---------------------------------------------------------------------------
  logic [AW-1:0] wp_r, wp_nxt;
  logic          wmem_we;

  assign wmem_we = wt_acc && (32'(wp_r) < 32'(kn));
  assign wp_nxt  = (32'(wp_r) + 32'd1 >= 32'(kn)) ? '0 : AW'(wp_r + 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
    end else if (wt_acc) begin
      wp_r <= wp_nxt;
    end
  end

  logic signed [ELEMENT_WIDTH-1:0] wmem [DEPTH];
  logic signed [ELEMENT_WIDTH-1:0] wdata_r;
  logic [AW-1:0]                   a_r;
  logic                            issue_r;

  always_ff @(posedge clk) begin
    if (wmem_we) begin
      wmem[wp_r] <= in_data.value;
    end
    if (issue_r) begin
      wdata_r <= wmem[a_r];
    end
  end

  // ---------------------------------------------------------------------------
  // Element pointer; the row's final element triggers the dot products.
  // A pointer already at or past K (after K shrank) completes the row too.
  // ---------------------------------------------------------------------------
  logic [EPW-1:0] ep_r;
  logic           ep_in_range;
  logic           ep_at_end;

  assign ep_in_range = 32'(ep_r) < 32'(k_eff);
  assign ep_at_end   = 32'(ep_r) + 32'd1 >= 32'(k_eff);
  assign row_trigger = act_acc && ep_at_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ep_r <= '0;
    end else if (act_acc) begin
      ep_r <= ep_at_end ? '0 : EPW'(ep_r + 1'b1);
    end
  end

  // ---------------------------------------------------------------------------
  // Row buffer: chain of cells. During compute the chain rotates by one each
  // cycle over the first K cells, so cell 0 always shows row_buffer[pos].
  // After K*N shifts the row is back in its original order.
  // ---------------------------------------------------------------------------
  logic signed [ELEMENT_WIDTH-1:0] cell_q [MAX_K];

  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    cell_ctrl_t ctrl;
    logic       is_tail;

    assign ctrl.wr_en    = act_acc && ep_in_range && (ep_r == EPW'(i));
    assign ctrl.shift_en = issue_r;
    assign is_tail       = (32'(i) + 32'd1) == 32'(k_eff);

    bmtb_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .wr_value (in_data.value),
      .next_q   (cell_q[(i + 1) % MAX_K]),
      .head_q   (cell_q[0]),
      .is_tail  (is_tail),
      .q        (cell_q[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Issue sequencer: walks address 0..K*N-1, position and column alongside
  // ---------------------------------------------------------------------------
  logic [EPW-1:0] p_r;
  logic [CW-1:0]  c_r;
  logic           last_pos;
  logic           last_col;

  assign last_pos = 32'(p_r) + 32'd1 >= 32'(k_eff);
  assign last_col = 32'(c_r) + 32'd1 >= 32'(n_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r <= 1'b0;
    end else if (row_trigger) begin
      issue_r <= 1'b1;
    end else if (issue_r && last_pos && last_col) begin
      issue_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (row_trigger) begin
      a_r <= '0;
      p_r <= '0;
      c_r <= '0;
    end else if (issue_r) begin
      a_r <= AW'(a_r + 1'b1);
      if (last_pos) begin
        p_r <= '0;
        c_r <= CW'(c_r + 1'b1);
      end else begin
        p_r <= EPW'(p_r + 1'b1);
      end
    end
  end

  // operands registered alongside the memory read
  mac_tag_t                        tag_r;
  logic signed [ELEMENT_WIDTH-1:0] act_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r.valid    <= issue_r;
      tag_r.first    <= (p_r == '0);
      tag_r.last_pos <= last_pos;
      tag_r.last_col <= last_col;
      tag_r.col      <= COL_W'(c_r);
    end
  end

  always_ff @(posedge clk) begin
    if (issue_r) begin
      act_r <= cell_q[0];
    end
  end

  logic                        res_valid;
  logic signed [SUM_WIDTH-1:0] res_sum;
  logic [COL_W-1:0]            res_col;
  logic                        res_last;

  bmtb_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag       (tag_r),
    .weight    (wdata_r),
    .act       (act_r),
    .res_valid (res_valid),
    .res_sum   (res_sum),
    .res_col   (res_col),
    .res_last  (res_last)
  );

  // ---------------------------------------------------------------------------
  // Row / slice / batch counters. Indices of the completed row are held for
  // the whole result burst; the counters move on at the trigger.
  // ---------------------------------------------------------------------------
  logic [ROW_W-1:0]   row_cnt_r;
  logic [DIM_W-1:0]   dim_cnt_r;
  logic [BATCH_W-1:0] batch_cnt_r;
  logic [ROW_W-1:0]   row_idx_r;
  logic [DIM_W-1:0]   dim_idx_r;
  logic [BATCH_W-1:0] batch_idx_r;
  logic               row_wrap;
  logic               dim_wrap;
  logic               batch_wrap;

  assign row_wrap   = 32'(row_cnt_r) + 32'd1 >= 32'(nr_eff);
  assign dim_wrap   = 32'(dim_cnt_r) + 32'd1 >= 32'(nd_eff);
  assign batch_wrap = 32'(batch_cnt_r) + 32'd1 >= 32'(nb_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r   <= '0;
      dim_cnt_r   <= '0;
      batch_cnt_r <= '0;
    end else if (row_trigger) begin
      if (row_wrap) begin
        row_cnt_r <= '0;
        if (dim_wrap) begin
          dim_cnt_r   <= '0;
          batch_cnt_r <= batch_wrap ? '0 : BATCH_W'(batch_cnt_r + 1'b1);
        end else begin
          dim_cnt_r <= DIM_W'(dim_cnt_r + 1'b1);
        end
      end else begin
        row_cnt_r <= ROW_W'(row_cnt_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (row_trigger) begin
      row_idx_r   <= row_cnt_r;
      dim_idx_r   <= dim_cnt_r;
      batch_idx_r <= batch_cnt_r;
    end
  end

  // busy from the trigger until the final column is out
  always_comb begin
    busy_nxt = busy_r;
    if (row_trigger) begin
      busy_nxt = 1'b1;
    end else if (res_valid && res_last) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Outputs
  // ---------------------------------------------------------------------------
  assign busy                 = busy_r;
  assign out_valid            = res_valid;
  assign out_data.sum         = res_sum;
  assign out_data.batch_index = batch_idx_r;
  assign out_data.dim_index   = dim_idx_r;
  assign out_data.row_index   = row_idx_r;
  assign out_data.col_index   = res_col;
  assign out_data.last        = res_last;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `ASSERT_IMPLIES(a_out_in_busy, clk, rst_n, out_valid, busy_r, "result strobe while idle")
  `ASSERT_IMPLIES(a_issue_in_busy, clk, rst_n, issue_r, busy_r, "MAC issue while idle")
  `ASSERT_NEXT(a_trigger_issue, clk, rst_n, row_trigger, issue_r && busy_r, "row not started")
  `ASSERT_NEXT(a_last_idle, clk, rst_n, out_valid && out_data.last, !busy_r && !issue_r, "busy after last column")

endmodule

// ----- hdl/bmtb_cell.sv -----
// One row buffer element. Loads on write, otherwise rotates toward the head on shift.
module bmtb_cell import bmtb_pkg::*; (
  input  logic                            clk,
  input  cell_ctrl_t                      ctrl,
  input  logic signed [ELEMENT_WIDTH-1:0] wr_value,
  input  logic signed [ELEMENT_WIDTH-1:0] next_q,
  input  logic signed [ELEMENT_WIDTH-1:0] head_q,
  input  logic                            is_tail,
  output logic signed [ELEMENT_WIDTH-1:0] q
);

  logic signed [ELEMENT_WIDTH-1:0] q_r;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      q_r <= wr_value;
    end else if (ctrl.shift_en) begin
      // tail of the active row takes the head back
      q_r <= is_tail ? head_q : next_q;
    end
  end

  assign q = q_r;

endmodule

// ----- hdl/bmtb_mac.sv -----
// Multiply stage then accumulate stage; emits the sum on the last position.
module bmtb_mac import bmtb_pkg::*; (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mac_tag_t                        tag,
  input  logic signed [ELEMENT_WIDTH-1:0] weight,
  input  logic signed [ELEMENT_WIDTH-1:0] act,
  output logic                            res_valid,
  output logic signed [SUM_WIDTH-1:0]     res_sum,
  output logic [COL_W-1:0]                res_col,
  output logic                            res_last
);

  logic signed [2*ELEMENT_WIDTH-1:0] prod_r;
  mac_tag_t                          tag2_r;
  logic signed [SUM_WIDTH-1:0]       acc_r;
  logic signed [SUM_WIDTH-1:0]       acc_nxt;
  logic                              res_valid_r;
  logic signed [SUM_WIDTH-1:0]       res_sum_r;
  logic [COL_W-1:0]                  res_col_r;
  logic                              res_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag2_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      tag2_r      <= tag;
      res_valid_r <= tag2_r.valid && tag2_r.last_pos;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= weight * act;
  end

  // exact sum, wraps modulo 2^SUM_WIDTH
  assign acc_nxt = (tag2_r.first ? '0 : acc_r) + SUM_WIDTH'(prod_r);

  always_ff @(posedge clk) begin
    if (tag2_r.valid) begin
      acc_r <= acc_nxt;
    end
    if (tag2_r.valid && tag2_r.last_pos) begin
      res_sum_r  <= acc_nxt;
      res_col_r  <= tag2_r.col;
      res_last_r <= tag2_r.last_col;
    end
  end

  assign res_valid = res_valid_r;
  assign res_sum   = res_sum_r;
  assign res_col   = res_col_r;
  assign res_last  = res_last_r;

endmodule

// ----- tb/tb_batched_matmul_transposed_b.sv -----
module tb_batched_matmul_transposed_b;
  import bmtb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // ---------------------------------------------------------------------------
  // DUT hookup
  // ---------------------------------------------------------------------------
  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  in_req_t                in_data;
  logic                   out_valid;
  out_res_t               out_data;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  batched_matmul_transposed_b dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  localparam int WMEM_DEPTH = DEF_MAX_K * DEF_MAX_N;

  // ---------------------------------------------------------------------------
  // Shadow of the block: weight memory, row buffer, pointers, counters and the
  // raw register contents (masked to register width, clamped on use).
  // ---------------------------------------------------------------------------
  logic signed [ELEMENT_WIDTH-1:0] wmem [0:WMEM_DEPTH-1];
  bit                              wset [0:WMEM_DEPTH-1];  // entry written since reset
  logic signed [ELEMENT_WIDTH-1:0] abuf [0:DEF_MAX_K-1];
  int unsigned wptr  = 0;
  int unsigned eptr  = 0;
  int unsigned row_n = 0;
  int unsigned dim_n = 0;
  int unsigned bat_n = 0;

  logic [CD_W-1:0]  r_cd  = CD_W'(64);
  logic [OC_W-1:0]  r_oc  = OC_W'(16);
  logic [RPS_W-1:0] r_rps = RPS_W'(1);
  logic [DS_W-1:0]  r_ds  = DS_W'(1);
  logic [BAT_W-1:0] r_bat = BAT_W'(1);

  out_res_t dot_due [$];   // dot products still owed by the block
  int       bad_count = 0;
  int       idle_pct  = 0; // chance in percent that the sender skips a cycle

  // zero behaves as one, oversize behaves as the ceiling
  function automatic int unsigned eff_size(int unsigned raw, int unsigned ceil);
    if (raw == 0) return 1;
    return (raw > ceil) ? ceil : raw;
  endfunction

  function automatic int unsigned k_eff();
    return eff_size(r_cd, DEF_MAX_K);
  endfunction

  function automatic int unsigned n_eff();
    return eff_size(r_oc, DEF_MAX_N);
  endfunction

  // every weight of the current K x N tile has been written at least once
  function automatic bit weights_loaded();
    int unsigned i;
    for (i = 0; i < k_eff() * n_eff(); i++)
      if (!wset[i]) return 1'b0;
    return 1'b1;
  endfunction

  // Advance the shadow by one accepted request; a row-completing activation
  // queues one dot product per column. Typed sums override the computed ones.
  function automatic void apply_request(cmd_t cmd, logic [ELEMENT_WIDTH-1:0] val, bit typed,
                                        logic signed [SUM_WIDTH-1:0] s0,
                                        logic signed [SUM_WIDTH-1:0] s1);
    int unsigned k, n, col, p;
    longint      acc;
    out_res_t    res;
    k = k_eff();
    n = n_eff();
    if (cmd == CMD_WEIGHT) begin
      if (wptr < k * n) begin
        wmem[wptr] = val;
        wset[wptr] = 1'b1;
      end
      wptr = (wptr + 1 >= k * n) ? 0 : wptr + 1;
      return;
    end
    if (eptr < k) abuf[eptr] = val;
    if (eptr + 1 < k) begin
      eptr++;
      return;
    end
    eptr = 0;
    for (col = 0; col < n; col++) begin
      acc = 0;
      for (p = 0; p < k; p++)
        acc += longint'(abuf[p]) * longint'(wmem[col * k + p]);
      res.sum         = acc[SUM_WIDTH-1:0];
      res.batch_index = bat_n[BATCH_W-1:0];
      res.dim_index   = dim_n[DIM_W-1:0];
      res.row_index   = row_n[ROW_W-1:0];
      res.col_index   = col[COL_W-1:0];
      res.last        = (col + 1 == n);
      if (typed) res.sum = (col == 0) ? s0 : s1;
      dot_due.push_back(res);
    end
    // row -> slice -> batch rollover
    if (row_n + 1 >= eff_size(r_rps, MAX_ROWS)) begin
      row_n = 0;
      if (dim_n + 1 >= eff_size(r_ds, MAX_SLICES)) begin
        dim_n = 0;
        bat_n = (bat_n + 1 >= eff_size(r_bat, MAX_BATCHES)) ? 0 : bat_n + 1;
      end else begin
        dim_n++;
      end
    end else begin
      row_n++;
    end
  endfunction

  // element values biased toward the corners of Q8.8
  function automatic logic [ELEMENT_WIDTH-1:0] rand_elem();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return ELEMENT_WIDTH'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("batched_matmul_transposed_b: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver tasks. Everything changes by NBA right after a rising edge, and
  // busy/out_valid are read in the same slot, i.e. the pre-edge values.
  // ---------------------------------------------------------------------------
  task automatic quiet();
    start  <= 1'b0;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // present one request and hold it until the block takes it
  task automatic issue(cmd_t cmd, logic [ELEMENT_WIDTH-1:0] val, bit typed,
                       logic signed [SUM_WIDTH-1:0] s0, logic signed [SUM_WIDTH-1:0] s1);
    while ($urandom_range(99) < idle_pct) quiet();
    in_data <= '{command: cmd, value: val};
    start   <= 1'b1;
    cfg_we  <= 1'b0;
    do @(posedge clk); while (busy);
    apply_request(cmd, val, typed, s0, s1);
  endtask

  // wait for the pipe to empty; weight requests leave no result behind, so
  // idle on past that before touching the registers
  task automatic drain();
    do quiet(); while (dot_due.size() != 0 || busy);
    repeat (4) quiet();
  endtask

  task automatic set_reg(cfg_reg_t sel, logic [CFG_DATA_W-1:0] val);
    start     <= 1'b0;
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= val;
    @(posedge clk);
    case (sel)
      CFG_COMMON_DIM:     r_cd  = val[CD_W-1:0];
      CFG_OUT_COLS:       r_oc  = val[OC_W-1:0];
      CFG_ROWS_PER_SLICE: r_rps = val[RPS_W-1:0];
      CFG_DIM_SLICES:     r_ds  = val[DS_W-1:0];
      CFG_BATCHES:        r_bat = val[BAT_W-1:0];
      default: ;
    endcase
  endtask

  // One configuration: program all registers, load the whole weight tile, then
  // a stream that is mostly activations with some stray weight writes mixed in.
  // A row is only closed once every weight it reads has been written.
  task automatic run_phase(logic [CFG_DATA_W-1:0] cd, logic [CFG_DATA_W-1:0] oc,
                           logic [CFG_DATA_W-1:0] rps, logic [CFG_DATA_W-1:0] ds,
                           logic [CFG_DATA_W-1:0] bt, int pct, int count);
    int unsigned i;
    drain();
    set_reg(CFG_COMMON_DIM, cd);
    set_reg(CFG_OUT_COLS, oc);
    set_reg(CFG_ROWS_PER_SLICE, rps);
    set_reg(CFG_DIM_SLICES, ds);
    set_reg(CFG_BATCHES, bt);
    idle_pct = pct;
    for (i = 0; i < k_eff() * n_eff(); i++)
      issue(CMD_WEIGHT, rand_elem(), 1'b0, '0, '0);
    for (i = 0; i < count; i++) begin
      if ($urandom_range(99) < 85 && (eptr + 1 < k_eff() || weights_loaded()))
        issue(CMD_ACT, rand_elem(), 1'b0, '0, '0);
      else
        issue(CMD_WEIGHT, rand_elem(), 1'b0, '0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed plan. Opens with four weight writes at the reset sizes (tile of
  // 1024), then shrinks to a 2x2 tile: the pointer is then past the new tile,
  // so the next weight write is dropped and the pointer restarts at zero.
  // Rows with typed sums use full-scale Q8.8 corners; slices = 2 and
  // batches = 2 with one row per slice make the index counters roll over.
  // The last block rewrites three weights after the tile wrapped.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic                        is_cfg;
    cfg_reg_t                    sel;
    logic [CFG_DATA_W-1:0]       cfg_val;
    cmd_t                        cmd;
    logic [ELEMENT_WIDTH-1:0]    val;
    logic                        typed;
    logic signed [SUM_WIDTH-1:0] sum0;
    logic signed [SUM_WIDTH-1:0] sum1;
  } plan_row_t;

  localparam int PLAN_LEN = 31;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{1'b0, CFG_COMMON_DIM,     13'd0, CMD_WEIGHT, 16'h1234, 1'b0, 40'sd0, 40'sd0},
    '{1'b0, CFG_COMMON_DIM,     13'd0, CMD_WEIGHT, 16'hFFFF, 1'b0, 40'sd0, 40'sd0},
    '{1'b0, CFG_COMMON_DIM,     13'd0, CMD_WEIGHT, 16'h0000, 1'b0, 40'sd0, 40'sd0},
    '{1'b0, CFG_COMMON_DIM,     13'd0, CMD_WEIGHT, 16'h5555, 1'b0, 40'sd0, 40'sd0},
    '{1'b1, CFG_COMMON_DIM,     13'd2, CMD_WEIGHT, 16'h0000, 1'b0, 40'sd0, 40'sd0},
    '{1'b1, CFG_OUT_COLS,       13'd2, CMD_WEIGHT, 16'h0000, 1'b0, 40'sd0, 40'sd0},
    '{1'b1, CFG_ROWS_PER_SLICE, 13'd1, CMD_WEIGHT, 16'h0000, 1'b0, 40'sd0, 40'sd0},
    '{1'b1, CFG_DIM_SLICES,     13'd2, CMD_WEIGHT, 16'h0000, 1'b0, 40'sd0, 40'sd0},
    '{1'b1, CFG_BATCHES,        13'd2, CMD_WEIGHT, 16'h0000, 1'b0, 40'sd0, 40'sd0},
    // dropped: pointer sits past the 2x2 tile
    '{1'b0, CFG_COMMON_DIM,     13'd0, CMD_WEIGHT, 16'h2AAA, 1'b0, 40'sd0, 40'sd0},
    '{1'b0, CFG_COMMON_DIM,     13'd0, CMD_WEIGHT, 16'h7FFF, 1'b0, 40'sd0, 40'sd0},
    '{1'b0, CFG_COMMON_DIM,     13'd0, CMD_WEIGHT, 16'h8000, 1'b0, 40'sd0, 40'sd0},
    '{1'b0, CFG_COMMON_DIM,     13'd0, CMD_WEIGHT, 16'h8000, 1'b0, 40'sd0, 40'sd0},
    '{1'b0, CFG_COMMON_DIM,     13'd0, CMD_WEIGHT, 16'h8000, 1'b0, 40'sd0, 40'sd0},
    '{1'b0, CFG_COMMON_DIM,     13'd0, CMD_ACT,    16'h8000, 1'b0, 40'sd0, 40'sd0},
    '{1'b0, CFG_COMMON_DIM,     13'd0, CMD_ACT,    16'h8000, 1'b1,
      40'sd32768, 40'sd2147483648},
    '{1'b0, CFG_COMMON_DIM,     13'd0, CMD_ACT,    16'h7FFF, 1'b0, 40'sd0, 40'sd0},
    '{1'b0, CFG_COMMON_DIM,     13'd0, CMD_ACT,    16'h7FFF, 1'b1,
      -40'sd32767, -40'sd2147418112},
    '{1'b0, CFG_COMMON_DIM,     13'd0, CMD_ACT,    16'hFFFF, 1'b0, 40'sd0, 40'sd0},
    '{1'b0, CFG_COMMON_DIM,     13'd0, CMD_ACT,    16'h0001, 1'b1,
      -40'sd65535, 40'sd0},
    '{1'b0, CFG_COMMON_DIM,     13'd0, CMD_ACT,    16'h0100, 1'b0, 40'sd0, 40'sd0},
    '{1'b0, CFG_COMMON_DIM,     13'd0, CMD_ACT,    16'hFF00, 1'b0, 40'sd0, 40'sd0},
    // tile wrapped: overwrite from entry zero
    '{1'b0, CFG_COMMON_DIM,     13'd0, CMD_WEIGHT, 16'h0001, 1'b0, 40'sd0, 40'sd0},
    '{1'b0, CFG_COMMON_DIM,     13'd0, CMD_WEIGHT, 16'h0002, 1'b0, 40'sd0, 40'sd0},
    '{1'b0, CFG_COMMON_DIM,     13'd0, CMD_WEIGHT, 16'hFFFE, 1'b0, 40'sd0, 40'sd0},
    '{1'b0, CFG_COMMON_DIM,     13'd0, CMD_ACT,    16'h0080, 1'b0, 40'sd0, 40'sd0},
    '{1'b0, CFG_COMMON_DIM,     13'd0, CMD_ACT,    16'h7F80, 1'b0, 40'sd0, 40'sd0},
    '{1'b0, CFG_COMMON_DIM,     13'd0, CMD_ACT,    16'h4000, 1'b0, 40'sd0, 40'sd0},
    '{1'b0, CFG_COMMON_DIM,     13'd0, CMD_ACT,    16'hC000, 1'b0, 40'sd0, 40'sd0},
    '{1'b0, CFG_COMMON_DIM,     13'd0, CMD_ACT,    16'h0000, 1'b0, 40'sd0, 40'sd0},
    '{1'b0, CFG_COMMON_DIM,     13'd0, CMD_ACT,    16'h0000, 1'b0, 40'sd0, 40'sd0}
  };

  // ---------------------------------------------------------------------------
  // Result checker: every strobe must match the oldest owed dot product.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_res_t want;
    if (rst_n && out_valid) begin
      if (dot_due.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("unexpected result: sum %0d b %0d d %0d r %0d c %0d last %0b",
                   out_data.sum, out_data.batch_index, out_data.dim_index,
                   out_data.row_index, out_data.col_index, out_data.last);
      end else begin
        want = dot_due.pop_front();
        if (want.sum !== out_data.sum || want.batch_index !== out_data.batch_index ||
            want.dim_index !== out_data.dim_index || want.row_index !== out_data.row_index ||
            want.col_index !== out_data.col_index || want.last !== out_data.last) begin
          bad_count++;
          if (bad_count <= 10)
            $display("result differs: exp sum %0d b %0d d %0d r %0d c %0d last %0b",
                     want.sum, want.batch_index, want.dim_index, want.row_index,
                     want.col_index, want.last,
                     " | got sum %0d b %0d d %0d r %0d c %0d last %0b",
                     out_data.sum, out_data.batch_index, out_data.dim_index,
                     out_data.row_index, out_data.col_index, out_data.last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int  i;
    bit  was_cfg;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed plan, no idling
    was_cfg = 1'b0;
    for (i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].is_cfg) begin
        if (!was_cfg) drain();
        set_reg(PLAN[i].sel, PLAN[i].cfg_val);
      end else begin
        issue(PLAN[i].cmd, PLAN[i].val, PLAN[i].typed, PLAN[i].sum0, PLAN[i].sum1);
      end
      was_cfg = PLAN[i].is_cfg;
    end

    // random phases: minimum sizes, zero and oversize values, write data wider
    // than a register (masked to its width, 13'h1F80 leaves zero in
    // common_dim), the full 16 columns; a phase can end mid-row so the next
    // one may start with the element pointer at or past K
    run_phase(3, 4, 2, 3, 2, 0, 6);
    run_phase(1, 1, 1, 1, 1, 71, 6);
    run_phase(0, 0, 0, 0, 0, 28, 5);
    run_phase(13'h1F80, 13'h1FFF, 8191, 511, 511, 71, 6);
    run_phase(5, 2, 3, 1, 3, 0, 12);
    run_phase(2, 3, 3, 2, 2, 28, 8);

    drain();
    repeat (20) @(posedge clk);
    if (bad_count == 0 && dot_due.size() == 0)
      $display("batched_matmul_transposed_b: match");
    else
      $display("batched_matmul_transposed_b: mismatch");
    $finish;
  end

endmodule
